// ===== rtl/alsa_pkg.sv =====
// ----------------------------------------------------------------------------
// alsa_pkg
// Types, codes and constants shared by the speech level and auto-stop block.
// ----------------------------------------------------------------------------
package alsa_pkg;

  localparam int BLOCK_MAX_DEF = 256;

  localparam int RAW_W     = 32;
  localparam int SHIFT     = 14;
  localparam int LEVEL_W   = 16;
  localparam int HIT_W     = 10;
  localparam int MS_W      = 24;
  localparam int BYTE_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  localparam logic [HIT_W-1:0] HIT_CAP = 10'd1000;
  localparam logic [MS_W-1:0]  MS_CAP  = {MS_W{1'b1}};

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_START  = 2'd2,
    OP_STOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_HITS_REQ  = 3'd1,
    CFG_SILENCE   = 3'd2,
    CFG_EARLIEST  = 3'd3,
    CFG_MIN_SPEECH = 3'd4,
    CFG_MAX       = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_HIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] threshold;
    logic [HIT_W-1:0]   hits_req;
    logic [MS_W-1:0]    silence_ms;
    logic [MS_W-1:0]    earliest_ms;
    logic [MS_W-1:0]    min_speech_ms;
    logic [MS_W-1:0]    max_ms;
  } cfg_t;

  typedef struct packed {
    logic            active;
    logic            auto_en;
    logic            seen;
    logic [MS_W-1:0] age_ms;
    logic [MS_W-1:0] since_ms;
  } rec_stat_t;

  // Result word, lowest field last.
  typedef struct packed {
    logic [1:0]         pad;
    logic               stopped;
    logic [BYTE_W-1:0]  bytes_recorded;
    logic               stop_due;
    logic               recording_on;
    logic               had_speech;
    logic [HIT_W-1:0]   speech_hits;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] sample_out;
  } out_t;

endpackage

// ===== rtl/alsa_div.sv =====
// ----------------------------------------------------------------------------
// alsa_div
// Restoring divider, one quotient bit per cycle, for the block mean level.
// ----------------------------------------------------------------------------
module alsa_div
  import alsa_pkg::*;
#(
  parameter int SUM_W = 24,
  parameter int CNT_W = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [LEVEL_W-1:0] quotient
);

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [SUM_W-1:0]  dvd;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    rem_shift;
  logic              fits;

  assign rem_shift = {rem, dvd[SUM_W-1]};
  assign fits      = rem_shift >= {1'b0, dsr};
  assign quotient  = quo[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(SUM_W);
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[SUM_W-2:0], 1'b0};
      quo <= {quo[SUM_W-2:0], fits};
      if (fits) begin
        rem <= CNT_W'(rem_shift - {1'b0, dsr});
      end else begin
        rem <= rem_shift[CNT_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/alsa_stop.sv =====
// ----------------------------------------------------------------------------
// alsa_stop
// Auto-stop decision from recording age, silence time and configured limits.
// ----------------------------------------------------------------------------
module alsa_stop
  import alsa_pkg::*;
(
  input  cfg_t      cfg,
  input  rec_stat_t stat,
  output logic      stop_due
);

  logic armed;
  logic at_max;
  logic silence_ok;

  assign armed  = stat.active && stat.auto_en && (stat.age_ms != '0);
  assign at_max = stat.age_ms >= cfg.max_ms;

  // Silence stop needs speech first and the recording past both age floors.
  assign silence_ok = stat.seen && (stat.age_ms >= cfg.earliest_ms)
                   && (stat.age_ms >= cfg.min_speech_ms)
                   && (stat.since_ms >= cfg.silence_ms);

  assign stop_due = armed && (at_max || silence_ok);

endmodule

// ===== rtl/audio_level_speech_autostop.sv =====
// ----------------------------------------------------------------------------
// audio_level_speech_autostop
// Microphone sample scaling, block mean level, speech hit counting and
// auto-stop timing.
// An item passes through the EXEC and DONE states to the output register; an
// item that closes a block also passes through DIV and HIT, waiting in DIV for
// the bit-serial divider that forms the mean level.
// One item at a time: the next transfer is taken once the result is loaded
// and the block is back in IDLE; DONE holds while the output is stalled.
// Reset (rst, synchronous) idles the block and loads the register defaults.
// ----------------------------------------------------------------------------
module audio_level_speech_autostop
  import alsa_pkg::*;
#(
  parameter int BLOCK_MAX = BLOCK_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // sample_raw[31:0], auto_stop[32], zero
  input  logic [1:0]           s_tuser,   // op[1:0]
  input  logic                 s_tlast,   // last_in_block
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // sample_out[15:0], level[31:16], speech_hits[41:32], had_speech[42],
  // recording_on[43], stop_due[44], bytes_recorded[76:45], stopped[77], zero
  output logic [79:0]          m_tdata,
  output logic [0:0]           m_tuser,   // sample_valid[0]
  output logic                 m_tlast,   // level_valid
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W = $clog2(BLOCK_MAX * 32768 + 1);

  state_t state, state_next;
  cfg_t   cfg;

  // Latched input item
  op_t              op_q;
  logic [RAW_W-1:0] raw_q;
  logic             last_q;
  logic             auto_q;

  // Recording state
  logic               active;
  logic               auto_en;
  logic               seen;
  logic [SUM_W-1:0]   block_sum;
  logic [CNT_W-1:0]   block_count;
  logic [LEVEL_W-1:0] last_level;
  logic [HIT_W-1:0]   hit_count;
  logic [MS_W-1:0]    age_ms;
  logic [MS_W-1:0]    since_ms;
  logic [BYTE_W-1:0]  byte_total;

  // Per-item result flags
  logic [LEVEL_W-1:0] smp_q;
  logic               smp_valid_q;
  logic               lvl_valid_q;
  logic               ended_q;

  out_t out_q;
  logic out_sv_q;
  logic out_lv_q;

  logic signed [RAW_W-SHIFT-1:0] shr;
  logic [LEVEL_W-1:0] smp;
  logic [LEVEL_W-1:0] abs_val;
  logic [SUM_W-1:0]   sum_new;
  logic [CNT_W-1:0]   cnt_new;
  logic               closes;
  logic               div_start;
  logic               div_done;
  logic [LEVEL_W-1:0] div_q;
  logic [HIT_W-1:0]   hit_up;
  logic               out_free;
  logic               stop_due;
  rec_stat_t          stat;

  // Arithmetic shift right keeps the top bits; then clamp to 16 bits.
  assign shr = raw_q[RAW_W-1:SHIFT];

  always_comb begin
    priority if (!shr[RAW_W-SHIFT-1] && (shr[RAW_W-SHIFT-2:LEVEL_W-1] != '0)) begin
      smp = 16'h7FFF;
    end else if (shr[RAW_W-SHIFT-1] && (shr[RAW_W-SHIFT-2:LEVEL_W-1] != '1)) begin
      smp = 16'h8000;
    end else begin
      smp = shr[LEVEL_W-1:0];
    end
  end

  assign abs_val   = smp[LEVEL_W-1] ? (~smp + 1'b1) : smp;
  assign sum_new   = block_sum + SUM_W'(abs_val);
  assign cnt_new   = block_count + 1'b1;
  assign closes    = last_q || (cnt_new == CNT_W'(BLOCK_MAX));
  assign div_start = (state == ST_EXEC) && (op_q == OP_SAMPLE) && active && closes;
  assign hit_up    = (hit_count < HIT_CAP) ? hit_count + 1'b1 : hit_count;
  assign out_free  = !m_tvalid || m_tready;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = out_q;
  assign m_tuser  = out_sv_q;
  assign m_tlast  = out_lv_q;

  assign stat.active   = active;
  assign stat.auto_en  = auto_en;
  assign stat.seen     = seen;
  assign stat.age_ms   = age_ms;
  assign stat.since_ms = since_ms;

  alsa_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (cnt_new),
    .done     (div_done),
    .quotient (div_q)
  );

  alsa_stop u_stop (
    .cfg      (cfg),
    .stat     (stat),
    .stop_due (stop_due)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = div_start ? ST_DIV : ST_DONE;
      ST_DIV: begin
        if (div_done) state_next = ST_HIT;
      end
      ST_HIT:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration and recording state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= 16'd300;
      cfg.hits_req      <= 10'd3;
      cfg.silence_ms    <= 24'd2000;
      cfg.earliest_ms   <= 24'd1000;
      cfg.min_speech_ms <= 24'd1500;
      cfg.max_ms        <= 24'd15000;
      active      <= 1'b0;
      auto_en     <= 1'b1;
      seen        <= 1'b0;
      block_sum   <= '0;
      block_count <= '0;
      last_level  <= '0;
      hit_count   <= '0;
      age_ms      <= '0;
      since_ms    <= '0;
      byte_total  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD:  cfg.threshold     <= cfg_data[LEVEL_W-1:0];
          CFG_HITS_REQ:   cfg.hits_req      <= cfg_data[HIT_W-1:0];
          CFG_SILENCE:    cfg.silence_ms    <= cfg_data[MS_W-1:0];
          CFG_EARLIEST:   cfg.earliest_ms   <= cfg_data[MS_W-1:0];
          CFG_MIN_SPEECH: cfg.min_speech_ms <= cfg_data[MS_W-1:0];
          CFG_MAX:        cfg.max_ms        <= cfg_data[MS_W-1:0];
          default: ;
        endcase
      end

      if (state == ST_EXEC) begin
        unique case (op_q)
          OP_SAMPLE: begin
            if (active) begin
              byte_total <= byte_total + BYTE_W'(2);
              if (closes) begin
                block_sum   <= '0;
                block_count <= '0;
              end else begin
                block_sum   <= sum_new;
                block_count <= cnt_new;
              end
            end
          end
          OP_TICK: begin
            if (active) begin
              if (age_ms != MS_CAP) age_ms <= age_ms + 1'b1;
              if (since_ms != MS_CAP) since_ms <= since_ms + 1'b1;
            end
          end
          OP_START: begin
            if (!active) begin
              active      <= 1'b1;
              auto_en     <= auto_q;
              block_sum   <= '0;
              block_count <= '0;
              last_level  <= '0;
              hit_count   <= '0;
              seen        <= 1'b0;
              age_ms      <= '0;
              since_ms    <= '0;
              byte_total  <= '0;
            end
          end
          OP_STOP: begin
            if (active) begin
              // The level and byte count survive so the last result can report them.
              active      <= 1'b0;
              auto_en     <= 1'b1;
              block_sum   <= '0;
              block_count <= '0;
              hit_count   <= '0;
              seen        <= 1'b0;
              age_ms      <= '0;
              since_ms    <= '0;
            end
          end
          default: ;
        endcase
      end

      if ((state == ST_DIV) && div_done) begin
        last_level <= div_q;
      end

      if (state == ST_HIT) begin
        if (last_level >= cfg.threshold) begin
          hit_count <= hit_up;
          if (hit_up >= cfg.hits_req) begin
            since_ms <= '0;
            seen     <= 1'b1;
          end
        end else if (hit_count != '0) begin
          hit_count <= hit_count - 1'b1;
        end
      end

      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Input latch, per-item flags and the output register
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && s_tvalid) begin
      op_q   <= op_t'(s_tuser);
      raw_q  <= s_tdata[RAW_W-1:0];
      auto_q <= s_tdata[RAW_W];
      last_q <= s_tlast;
    end
    if (state == ST_EXEC) begin
      smp_valid_q <= (op_q == OP_SAMPLE) && active;
      smp_q       <= ((op_q == OP_SAMPLE) && active) ? smp : '0;
      lvl_valid_q <= div_start;
      ended_q     <= (op_q == OP_STOP) && active;
    end
    if ((state == ST_DONE) && out_free) begin
      out_q.pad            <= '0;
      out_q.stopped        <= ended_q;
      out_q.bytes_recorded <= byte_total;
      out_q.stop_due       <= stop_due;
      out_q.recording_on   <= active;
      out_q.had_speech     <= seen;
      out_q.speech_hits    <= hit_count;
      out_q.level          <= last_level;
      out_q.sample_out     <= smp_q;
      out_sv_q             <= smp_valid_q;
      out_lv_q             <= lvl_valid_q;
    end
  end

  a_hit_cap: assert property (@(posedge clk) disable iff (rst)
    hit_count <= HIT_CAP)
    else $error("speech hit count above its cap");

  a_block_open: assert property (@(posedge clk) disable iff (rst)
    block_count < CNT_W'(BLOCK_MAX))
    else $error("open block holds a full block of samples");

  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_level_has_sample: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("level result without a recorded sample");

  a_stop_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_q.stopped |-> !out_q.recording_on && !out_q.stop_due)
    else $error("stop result still shows an active recording");

endmodule
